/* src/ssp_pkg.sv */
`timescale 1ns / 1ps
// Package for the schema spec parser: parse phase type, result kind codes,
// character codes and the structs used by the parser step and the output queue.
// No dependencies.
package ssp_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_NAME    = 4'd1,
    PH_TYPE    = 4'd2,
    PH_TYPE_I  = 4'd3,
    PH_SIZE    = 4'd4,
    PH_AFTER   = 4'd5,
    PH_FLAG1   = 4'd6,
    PH_FLAG2   = 4'd7,
    PH_DISCARD = 4'd8
  } phase_e;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] TYPE_I1 = 2'd0;
  localparam logic [1:0] TYPE_I2 = 2'd1;
  localparam logic [1:0] TYPE_I4 = 2'd2;
  localparam logic [1:0] TYPE_C  = 2'd3;

  localparam logic [1:0] LETTER_NONE = 2'd0;
  localparam logic [1:0] LETTER_P    = 2'd1;
  localparam logic [1:0] LETTER_A    = 2'd2;
  localparam logic [1:0] LETTER_N    = 2'd3;

  localparam int unsigned FLAG_PK = 0;
  localparam int unsigned FLAG_AI = 1;
  localparam int unsigned FLAG_NU = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_U     = 8'h55;

  localparam logic [7:0] SIZE_MAX = 8'd250;
  localparam logic [7:0] SIZE_SAT = 8'd255;

  localparam int unsigned NAME_BYTES = 15;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] name_count;
    logic [1:0] type_held;
    logic [7:0] size_acc;
    logic [2:0] flag_bits;
    logic [1:0] flag_letter;
    logic [6:0] fields_done;
  } ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_low;
    logic [55:0] name_high;
    logic [3:0]  name_length;
    logic [1:0]  field_type;
    logic [7:0]  field_size;
    logic        is_primary_key;
    logic        is_auto_increment;
    logic        is_nullable;
    logic [6:0]  field_count;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } qent_t;

endpackage

/* src/ssp_step.sv */
`timescale 1ns / 1ps
// Combinational parser step: next parse state and up to two results for one character.
// Depends on ssp_pkg.
module ssp_step #(
  parameter int unsigned NAME_CHARS = 15
) (
  input  logic [7:0]         ch_i,
  input  logic [6:0]         max_fields_i,
  input  ssp_pkg::ctl_t      ctl_i,
  input  logic [7:0]         store_i [NAME_CHARS],
  output ssp_pkg::ctl_t      ctl_o,
  output logic [7:0]         store_o [NAME_CHARS],
  output logic [1:0]         res_cnt_o,
  output ssp_pkg::res_t      res0_o,
  output ssp_pkg::res_t      res1_o
);

  logic [119:0]  name_flat;
  ssp_pkg::res_t rec;
  ssp_pkg::res_t stop_res;
  logic [1:0]    rec_type;
  logic [11:0]   acc_v;
  logic          is_digit;
  logic          do_name, do_type, do_after, do_stop;
  logic [1:0]    stop_kind;
  logic [1:0]    n;

  function automatic ssp_pkg::ctl_t clear_field(input ssp_pkg::ctl_t c);
    ssp_pkg::ctl_t r;
    r             = c;
    r.name_count  = '0;
    r.type_held   = '0;
    r.size_acc    = '0;
    r.flag_bits   = '0;
    r.flag_letter = '0;
    return r;
  endfunction

  // Name bytes beyond the configured store read as zero.
  for (genvar g = 0; g < ssp_pkg::NAME_BYTES; g++) begin : g_name
    if (g < NAME_CHARS) begin : g_used
      assign name_flat[8*g +: 8] = store_i[g];
    end else begin : g_zero
      assign name_flat[8*g +: 8] = 8'h00;
    end
  end

  // A C size closes into a record with the type forced to C.
  assign rec_type = (ctl_i.phase == ssp_pkg::PH_SIZE) ? ssp_pkg::TYPE_C : ctl_i.type_held;
  assign is_digit = (ch_i >= ssp_pkg::CH_ZERO) && (ch_i <= ssp_pkg::CH_NINE);
  assign acc_v    = {1'b0, ctl_i.size_acc, 3'b000} + {3'b000, ctl_i.size_acc, 1'b0}
                  + {8'h00, ch_i[3:0]};

  always_comb begin
    rec                   = '0;
    rec.kind              = ssp_pkg::KIND_RECORD;
    rec.name_low          = name_flat[63:0];
    rec.name_high         = name_flat[119:64];
    rec.name_length       = ctl_i.name_count;
    rec.field_type        = rec_type;
    case (rec_type)
      ssp_pkg::TYPE_I1: rec.field_size = 8'd1;
      ssp_pkg::TYPE_I2: rec.field_size = 8'd2;
      ssp_pkg::TYPE_I4: rec.field_size = 8'd4;
      default:          rec.field_size = ctl_i.size_acc;
    endcase
    rec.is_primary_key    = ctl_i.flag_bits[ssp_pkg::FLAG_PK];
    rec.is_auto_increment = ctl_i.flag_bits[ssp_pkg::FLAG_AI];
    rec.is_nullable       = ctl_i.flag_bits[ssp_pkg::FLAG_NU];
    rec.field_count       = ctl_i.fields_done;
  end

  always_comb begin
    ctl_o     = ctl_i;
    store_o   = store_i;
    n         = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    stop_res  = '0;
    do_name   = 1'b0;
    do_type   = 1'b0;
    do_after  = 1'b0;
    do_stop   = 1'b0;
    stop_kind = ssp_pkg::KIND_DONE;

    unique case (ctl_i.phase)
      ssp_pkg::PH_START: begin
        if (ch_i == ssp_pkg::CH_NUL || ctl_i.fields_done >= max_fields_i) begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_DONE;
        end else begin
          ctl_o   = clear_field(ctl_o);
          store_o = '{default: '0};
          do_name = 1'b1;
        end
      end
      ssp_pkg::PH_NAME: do_name = 1'b1;
      ssp_pkg::PH_TYPE: do_type = 1'b1;
      ssp_pkg::PH_TYPE_I: begin
        ctl_o.phase = ssp_pkg::PH_AFTER;
        if (ch_i == ssp_pkg::CH_ONE) begin
          ctl_o.type_held = ssp_pkg::TYPE_I1;
        end else if (ch_i == ssp_pkg::CH_TWO) begin
          ctl_o.type_held = ssp_pkg::TYPE_I2;
        end else if (ch_i == ssp_pkg::CH_FOUR) begin
          ctl_o.type_held = ssp_pkg::TYPE_I4;
        end else begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_ERROR;
        end
      end
      ssp_pkg::PH_SIZE: begin
        if (is_digit) begin
          ctl_o.size_acc = (acc_v > 12'd255) ? ssp_pkg::SIZE_SAT : acc_v[7:0];
        end else if (ctl_i.size_acc == 8'd0 || ctl_i.size_acc > ssp_pkg::SIZE_MAX) begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_ERROR;
        end else begin
          ctl_o.type_held = ssp_pkg::TYPE_C;
          do_after        = 1'b1;
        end
      end
      ssp_pkg::PH_AFTER: do_after = 1'b1;
      ssp_pkg::PH_FLAG1: begin
        ctl_o.phase = ssp_pkg::PH_FLAG2;
        if (ch_i == ssp_pkg::CH_P) begin
          ctl_o.flag_letter = ssp_pkg::LETTER_P;
        end else if (ch_i == ssp_pkg::CH_A) begin
          ctl_o.flag_letter = ssp_pkg::LETTER_A;
        end else if (ch_i == ssp_pkg::CH_N) begin
          ctl_o.flag_letter = ssp_pkg::LETTER_N;
        end else begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_ERROR;
        end
      end
      ssp_pkg::PH_FLAG2: begin
        ctl_o.phase = ssp_pkg::PH_AFTER;
        if (ctl_i.flag_letter == ssp_pkg::LETTER_P && ch_i == ssp_pkg::CH_K) begin
          ctl_o.flag_bits[ssp_pkg::FLAG_PK] = 1'b1;
        end else if (ctl_i.flag_letter == ssp_pkg::LETTER_A && ch_i == ssp_pkg::CH_I) begin
          ctl_o.flag_bits[ssp_pkg::FLAG_AI] = 1'b1;
        end else if (ctl_i.flag_letter == ssp_pkg::LETTER_N && ch_i == ssp_pkg::CH_U) begin
          ctl_o.flag_bits[ssp_pkg::FLAG_NU] = 1'b1;
        end else if (!(ctl_i.flag_letter == ssp_pkg::LETTER_N && ch_i == ssp_pkg::CH_N)) begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_ERROR;
        end
      end
      default: begin
        // Discarding up to the terminator; the terminator itself restarts the text.
        if (ch_i == ssp_pkg::CH_NUL) begin
          ctl_o             = clear_field(ctl_o);
          ctl_o.phase       = ssp_pkg::PH_START;
          ctl_o.fields_done = '0;
          store_o           = '{default: '0};
        end else begin
          ctl_o.phase = ssp_pkg::PH_DISCARD;
        end
      end
    endcase

    // A field is complete: either a flag follows or the record goes out.
    if (do_after) begin
      if (ch_i == ssp_pkg::CH_COLON) begin
        ctl_o.phase = ssp_pkg::PH_FLAG1;
      end else begin
        res0_o            = rec;
        n                 = 2'd1;
        ctl_o.fields_done = 7'(ctl_i.fields_done + 7'd1);
        if (ctl_o.fields_done >= max_fields_i || ch_i == ssp_pkg::CH_NUL) begin
          do_stop   = 1'b1;
          stop_kind = ssp_pkg::KIND_DONE;
        end else if (ch_i == ssp_pkg::CH_COMMA) begin
          ctl_o       = clear_field(ctl_o);
          store_o     = '{default: '0};
          ctl_o.phase = ssp_pkg::PH_START;
        end else begin
          ctl_o   = clear_field(ctl_o);
          store_o = '{default: '0};
          do_name = 1'b1;
        end
      end
    end

    if (do_name) begin
      if (ch_i == ssp_pkg::CH_COLON) begin
        ctl_o.phase = ssp_pkg::PH_TYPE;
      end else if (ch_i != ssp_pkg::CH_COMMA && ch_i != ssp_pkg::CH_NUL
                   && ctl_o.name_count < 4'(NAME_CHARS)) begin
        for (int i = 0; i < NAME_CHARS; i++) begin
          if (ctl_o.name_count == 4'(i)) begin
            store_o[i] = ch_i;
          end
        end
        ctl_o.name_count = ctl_o.name_count + 4'd1;
        ctl_o.phase      = ssp_pkg::PH_NAME;
      end else begin
        // A name that cannot take this character hands it to the type.
        do_type = 1'b1;
      end
    end

    if (do_type) begin
      if (ch_i == ssp_pkg::CH_I) begin
        ctl_o.phase = ssp_pkg::PH_TYPE_I;
      end else if (ch_i == ssp_pkg::CH_C) begin
        ctl_o.size_acc = '0;
        ctl_o.phase    = ssp_pkg::PH_SIZE;
      end else begin
        do_stop   = 1'b1;
        stop_kind = ssp_pkg::KIND_ERROR;
      end
    end

    if (do_stop) begin
      stop_res.kind        = stop_kind;
      stop_res.field_count = ctl_o.fields_done;
      if (n == 2'd0) begin
        res0_o = stop_res;
      end else begin
        res1_o = stop_res;
      end
      n = n + 2'd1;
      if (ch_i == ssp_pkg::CH_NUL) begin
        ctl_o             = clear_field(ctl_o);
        ctl_o.phase       = ssp_pkg::PH_START;
        ctl_o.fields_done = '0;
        store_o           = '{default: '0};
      end else begin
        ctl_o.phase = ssp_pkg::PH_DISCARD;
      end
    end

    res_cnt_o = n;
  end

endmodule

/* src/ssp_outq.sv */
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results per cycle and hands out one.
// Depends on ssp_pkg.
module ssp_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  ssp_pkg::res_t       push0_i,
  input  ssp_pkg::res_t       push1_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output ssp_pkg::qent_t      head_o
);

  ssp_pkg::qent_t entry_q [4];
  logic [1:0]     wr_ptr_q, wr_ptr_d;
  logic [1:0]     rd_ptr_q, rd_ptr_d;
  logic [2:0]     count_q, count_d;
  logic           pop;

  assign pop     = pop_i && (count_q != 3'd0);
  assign valid_o = (count_q != 3'd0);
  assign head_o  = entry_q[rd_ptr_q];
  // Room for the worst case of two results from the next character.
  assign room_o  = (count_q <= 3'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_cnt_i} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= '{res: push0_i, last: (push_cnt_i == 2'd1)};
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= '{res: push1_i, last: 1'b1};
    end
  end

endmodule

/* src/schema_spec_parser.sv */
`timescale 1ns / 1ps
// Top level of the schema spec parser: input handshake, parse state registers,
// max_fields register and result stream. Depends on ssp_pkg, ssp_step and ssp_outq.
//
// Usage:
// The slave stream carries one text character per item in s_axis_tdata; a zero
// byte ends a text. The master stream carries result items: tuser holds the kind
// (field record, done with count, or error), tdata holds the record payload and
// tlast marks the final result caused by one character. A character can cause no
// result, one result, or a record followed by done.
// A result is queued when its character is accepted and shows on the master side
// after older results. Throughput: one character per cycle while the queue has
// room. The parse step is a single pass of logic between the state registers and
// a four-entry result queue, so the only limit is the master side: a record
// followed by done is two results. s_axis_tready is high while the queue holds
// two results or fewer, so a stalled receiver keeps taking characters until three
// or four results wait and then holds the input off; no result is lost or
// repeated while m_axis_tready is low. The configuration channel is always ready
// and writes max_fields (7 bits); the user must write it only while the block is
// idle (not enforced). Reset clears the parse state to the start of a text, the
// field count to zero, empties the result queue and sets max_fields to 32.
module schema_spec_parser #(
  parameter int unsigned NAME_CHARS = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Character stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] name_low, [119:64] name_high, [123:120] name_length,
  // [125:124] field_type, [133:126] field_size, [134] is_primary_key,
  // [135] is_auto_increment, [136] is_nullable, [143:137] field_count
  output logic [143:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast,
  // Configuration write of max_fields.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i
);

  ssp_pkg::ctl_t  ctl_q, ctl_d;
  logic [7:0]     store_q [NAME_CHARS];
  logic [7:0]     store_d [NAME_CHARS];
  logic [6:0]     max_fields_q;
  logic [1:0]     res_cnt;
  ssp_pkg::res_t  res0, res1;
  ssp_pkg::qent_t head;
  logic           accept;
  logic           room;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;
  assign cfg_ready_o = 1'b1;

  ssp_step #(
    .NAME_CHARS (NAME_CHARS)
  ) u_step (
    .ch_i         (s_axis_tdata),
    .max_fields_i (max_fields_q),
    .ctl_i        (ctl_q),
    .store_i      (store_q),
    .ctl_o        (ctl_d),
    .store_o      (store_d),
    .res_cnt_o    (res_cnt),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  // The parse state moves only on an accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{phase: ssp_pkg::PH_START, default: '0};
    end else if (accept) begin
      ctl_q <= ctl_d;
    end
  end

  // The name store is cleared at the start of every field before it is read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= 7'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_fields_q <= cfg_data_i;
    end
  end

  ssp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (accept ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (m_axis_tready),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tuser = head.res.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {head.res.field_count,
                         head.res.is_nullable,
                         head.res.is_auto_increment,
                         head.res.is_primary_key,
                         head.res.field_size,
                         head.res.field_type,
                         head.res.name_length,
                         head.res.name_high,
                         head.res.name_low};

endmodule

/* src/ssp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the schema spec parser, bound to the top level.
// Depends on ssp_pkg and schema_spec_parser's ports.
module ssp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // Only record, done and error kinds exist.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ssp_pkg::KIND_ERROR)
    else $error("result kind out of range");

  // Done and error carry only the count.
  a_stop_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ssp_pkg::KIND_RECORD) |-> m_axis_tdata[136:0] == '0)
    else $error("done or error result carries field payload");

  // Done and error always close the results of their character.
  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ssp_pkg::KIND_RECORD) |-> m_axis_tlast)
    else $error("done or error result not marked last");

  // A record always has a size of at least one byte.
  a_record_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ssp_pkg::KIND_RECORD) |->
      m_axis_tdata[133:126] != 8'd0)
    else $error("field record with zero size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind schema_spec_parser ssp_checker u_ssp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
